@@ hw/rtl/wfp_pkg.sv @@
package wfp_pkg;

	localparam int LEN_W = 63;
	localparam int FRAME_W = 64;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;

	localparam logic [6:0] IND_EXT16 = 7'd126;
	localparam logic [6:0] IND_EXT64 = 7'd127;
	localparam logic [15:0] MIN_EXT16 = 16'd126;
	localparam logic [FRAME_W-1:0] CTRL_MAX_LEN = 64'd125;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES = 4'd4;
	localparam logic [3:0] BASE_HDR_BYTES = 4'd2;
	localparam logic [3:0] OP_PING_LIMIT = 4'hb;

	typedef enum logic [2:0] {
		PH_BYTE1,
		PH_BYTE2,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD,
		PH_DEAD
	} phase_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             fin_flag;
		logic [3:0]       opcode;
		logic             masked_flag;
		logic [LEN_W-1:0] length;
		logic [3:0]       header_bytes;
		logic [7:0]       data_out;
		logic             last;
	} result_t;

endpackage

@@ hw/rtl/websocket_frame_parser_top.sv @@
// channel | signals                     | direction | word
// in      | in_valid, in_ready          | input     | byte_in
// out     | out_valid, out_ready        | output    | kind .. last
//
// One byte per cycle sustained while out_ready is high; a byte's result, if it has one,
// passes from the input stage into the result register. The rate is set by the parse state update, done once per byte.
// Reset clears the valid flags of the input stage and the result register and all parse state.
// With out_ready low the result holds and one more byte waits in the
// input stage; in_ready then drops until the result is taken.
module websocket_frame_parser_top import wfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       byte_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic             fin_flag,
	output logic [3:0]       opcode,
	output logic             masked_flag,
	output logic [LEN_W-1:0] length,
	output logic [3:0]       header_bytes,
	output logic [7:0]       data_out,
	output logic             last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       produce;
	result_t    core_res;
	result_t    out_res;

	assign adv = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_in;
		end
	end

	wfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.byte_s1 (byte_s1),
		.produce (produce),
		.result  (core_res)
	);

	wfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (produce),
		.load_data (core_res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_res)
	);

	assign kind = out_res.kind;
	assign fin_flag = out_res.fin_flag;
	assign opcode = out_res.opcode;
	assign masked_flag = out_res.masked_flag;
	assign length = out_res.length;
	assign header_bytes = out_res.header_bytes;
	assign data_out = out_res.data_out;
	assign last = out_res.last;

	a_invalid_no_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_INVALID) |-> !last)
		else $error("invalid result carries last");

	a_empty_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_HEADER) && last |-> (length == '0))
		else $error("header with last on nonempty frame");

	a_dead_after_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (kind == KIND_INVALID) |=> !out_valid)
		else $error("result after invalid frame");

	a_header_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (header_bytes >= BASE_HDR_BYTES))
		else $error("header size below minimum");

endmodule

@@ hw/rtl/wfp_core.sv @@
module wfp_core import wfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] byte_s1,
	output logic       produce,
	output result_t    result
);

	phase_t             phase_q, phase_d;
	logic [3:0]         fc_q, fc_d;
	logic [7:0]         hb_q, hb_d;
	logic               mp_q, mp_d;
	logic [6:0]         li_q, li_d;
	logic [FRAME_W-1:0] fl_q, fl_d;
	logic [31:0]        mk_q, mk_d;
	logic [LEN_W-1:0]   bl_q, bl_d;
	logic [1:0]         ki_q, ki_d;
	logic [3:0]         ht_q, ht_d;

	logic       al_req, fin_req, fail_req, pay;
	logic       last_d;
	logic [7:0] kb, data_d;

	function automatic logic header_bad(input logic [7:0] hb, input logic [FRAME_W-1:0] fl);
		logic ctrl;
		logic bad;
		ctrl = hb[3];
		bad = (hb[6:4] != 3'd0);
		if (ctrl && !hb[7])
			bad = 1'b1;
		if (ctrl && (fl > CTRL_MAX_LEN))
			bad = 1'b1;
		if ((hb[3:0] inside {[4'd3:4'd7]}) || (hb[3:0] >= OP_PING_LIMIT))
			bad = 1'b1;
		return bad;
	endfunction

	always_comb begin
		phase_d = phase_q;
		fc_d = fc_q;
		hb_d = hb_q;
		mp_d = mp_q;
		li_d = li_q;
		fl_d = fl_q;
		mk_d = mk_q;
		bl_d = bl_q;
		ki_d = ki_q;
		ht_d = ht_q;
		al_req = 1'b0;
		fin_req = 1'b0;
		fail_req = 1'b0;
		pay = 1'b0;
		last_d = 1'b0;
		data_d = 8'd0;
		kb = 8'd0;
		case (phase_q)
			PH_BYTE1: begin
				hb_d = byte_s1;
				phase_d = PH_BYTE2;
			end
			PH_BYTE2: begin
				mp_d = byte_s1[7];
				li_d = byte_s1[6:0];
				ht_d = BASE_HDR_BYTES;
				fl_d = '0;
				fc_d = 4'd0;
				mk_d = 32'd0;
				ki_d = 2'd0;
				if (byte_s1[6:0] >= IND_EXT16) begin
					phase_d = PH_EXTLEN;
				end else begin
					fl_d = {{(FRAME_W-7){1'b0}}, byte_s1[6:0]};
					al_req = 1'b1;
				end
			end
			PH_EXTLEN: begin
				fl_d = {fl_q[FRAME_W-9:0], byte_s1};
				fc_d = fc_q + 4'd1;
				ht_d = ht_q + 4'd1;
				if (li_q != IND_EXT64) begin
					if (fc_d == EXT16_BYTES) begin
						if (fl_d < {{(FRAME_W-16){1'b0}}, MIN_EXT16})
							fail_req = 1'b1;
						else
							al_req = 1'b1;
					end
				end else if (fc_d == EXT64_BYTES) begin
					if ((fl_d[FRAME_W-1:16] == '0) || fl_d[FRAME_W-1])
						fail_req = 1'b1;
					else
						al_req = 1'b1;
				end
			end
			PH_KEY: begin
				mk_d = {mk_q[23:0], byte_s1};
				fc_d = fc_q + 4'd1;
				ht_d = ht_q + 4'd1;
				if (fc_d == KEY_BYTES)
					fin_req = 1'b1;
			end
			PH_PAYLOAD: begin
				if (mp_q) begin
					case (ki_q)
						2'd0: kb = mk_q[31:24];
						2'd1: kb = mk_q[23:16];
						2'd2: kb = mk_q[15:8];
						default: kb = mk_q[7:0];
					endcase
				end
				ki_d = ki_q + 2'd1;
				if (bl_q != '0)
					bl_d = bl_q - {{(LEN_W-1){1'b0}}, 1'b1};
				last_d = (bl_d == '0);
				if (last_d)
					phase_d = PH_BYTE1;
				data_d = byte_s1 ^ kb;
				pay = 1'b1;
			end
			default: begin
			end
		endcase

		if (al_req) begin
			if (mp_d) begin
				fc_d = 4'd0;
				phase_d = PH_KEY;
			end else begin
				fin_req = 1'b1;
			end
		end
		if (fin_req) begin
			if (header_bad(hb_d, fl_d)) begin
				fail_req = 1'b1;
			end else if (fl_d == '0) begin
				phase_d = PH_BYTE1;
				last_d = 1'b1;
			end else begin
				bl_d = fl_d[LEN_W-1:0];
				ki_d = 2'd0;
				phase_d = PH_PAYLOAD;
			end
		end
		if (fail_req) begin
			phase_d = PH_DEAD;
			last_d = 1'b0;
		end

		produce = fire && (pay || fin_req || fail_req);
		result.kind = fail_req ? KIND_INVALID : (pay ? KIND_DATA : KIND_HEADER);
		result.fin_flag = hb_d[7];
		result.opcode = hb_d[3:0];
		result.masked_flag = mp_d;
		result.length = fl_d[LEN_W-1:0];
		result.header_bytes = ht_d;
		result.data_out = data_d;
		result.last = last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BYTE1;
			fc_q <= 4'd0;
			hb_q <= 8'd0;
			mp_q <= 1'b0;
			li_q <= 7'd0;
			fl_q <= '0;
			mk_q <= 32'd0;
			bl_q <= '0;
			ki_q <= 2'd0;
			ht_q <= BASE_HDR_BYTES;
		end else if (fire) begin
			phase_q <= phase_d;
			fc_q <= fc_d;
			hb_q <= hb_d;
			mp_q <= mp_d;
			li_q <= li_d;
			fl_q <= fl_d;
			mk_q <= mk_d;
			bl_q <= bl_d;
			ki_q <= ki_d;
			ht_q <= ht_d;
		end
	end

endmodule

@@ hw/rtl/wfp_out_reg.sv @@
module wfp_out_reg import wfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_data,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t out_data
);

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

@@ tb/tb_websocket_frame_parser_top.sv @@
`timescale 1ns / 1ps

module tb_websocket_frame_parser_top;
	import wfp_pkg::*;

	typedef enum logic [3:0] {
		OP_CONT     = 4'd0,
		OP_TEXT     = 4'd1,
		OP_BINARY   = 4'd2,
		OP_RSV_LO   = 4'd3,
		OP_RSV_HI   = 4'd7,
		OP_CLOSE    = 4'd8,
		OP_PING     = 4'd9,
		OP_PONG     = 4'd10,
		OP_RSV_CTRL = 4'd11,
		OP_RSV_TOP  = 4'd15
	} opcode_t;

	typedef enum int {
		BAD_SHORT16,
		BAD_SHORT64,
		BAD_TOPBIT,
		BAD_RSV,
		BAD_OPCODE,
		BAD_CTRL_FRAG,
		BAD_CTRL_LONG
	} bad_frame_t;

	typedef enum logic [1:0] {
		SINK_FREE,
		SINK_HALF,
		SINK_QUARTER,
		SINK_RANDOM
	} sink_mode_t;

	localparam logic [63:0] EXT64_MIN_LEN = 64'd65536;
	localparam int MAX_PRINTED = 40;

	class frame_scoreboard;
		phase_t      phase;
		logic [3:0]  field_count;
		logic [7:0]  hdr;
		logic        masked;
		logic [6:0]  len_ind;
		logic [63:0] frame_len;
		logic [31:0] mask_key;
		logic [62:0] remaining;
		logic [1:0]  key_idx;
		logic [3:0]  hdr_total;
		result_t     expected_q[$];
		int          errors;

		function new();
			phase = PH_BYTE1;
			field_count = '0;
			hdr = '0;
			masked = 1'b0;
			len_ind = '0;
			frame_len = '0;
			mask_key = '0;
			remaining = '0;
			key_idx = '0;
			hdr_total = BASE_HDR_BYTES;
			errors = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void emit(logic [1:0] kind, logic [7:0] data, logic last);
			result_t r;
			r.kind = kind;
			r.fin_flag = hdr[7];
			r.opcode = hdr[3:0];
			r.masked_flag = masked;
			r.length = frame_len[62:0];
			r.header_bytes = hdr_total;
			r.data_out = data;
			r.last = last;
			expected_q.push_back(r);
		endfunction

		function void fail_frame();
			phase = PH_DEAD;
			emit(KIND_INVALID, 8'h00, 1'b0);
		endfunction

		function void close_header();
			logic [3:0] op;
			op = hdr[3:0];
			if (hdr[6:4] != 3'b000 || (op[3] && (!hdr[7] || frame_len > CTRL_MAX_LEN)) ||
			    (op >= OP_RSV_LO && op <= OP_RSV_HI) || op >= OP_RSV_CTRL) begin
				fail_frame();
			end else if (frame_len == '0) begin
				phase = PH_BYTE1;
				emit(KIND_HEADER, 8'h00, 1'b1);
			end else begin
				remaining = frame_len[62:0];
				key_idx = '0;
				phase = PH_PAYLOAD;
				emit(KIND_HEADER, 8'h00, 1'b0);
			end
		endfunction

		function void end_of_length();
			if (masked) begin
				field_count = '0;
				phase = PH_KEY;
			end else begin
				close_header();
			end
		endfunction

		function void note_byte(logic [7:0] b);
			logic [7:0] kb;
			case (phase)
			PH_BYTE1: begin
				hdr = b;
				phase = PH_BYTE2;
			end
			PH_BYTE2: begin
				masked = b[7];
				len_ind = b[6:0];
				hdr_total = BASE_HDR_BYTES;
				frame_len = '0;
				field_count = '0;
				mask_key = '0;
				key_idx = '0;
				if (len_ind >= IND_EXT16) begin
					phase = PH_EXTLEN;
				end else begin
					frame_len = 64'(len_ind);
					end_of_length();
				end
			end
			PH_EXTLEN: begin
				frame_len = {frame_len[55:0], b};
				field_count = field_count + 4'd1;
				hdr_total = hdr_total + 4'd1;
				if (field_count == ((len_ind == IND_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
					if (len_ind == IND_EXT16 && frame_len < 64'(MIN_EXT16))
						fail_frame();
					else if (len_ind != IND_EXT16 && (frame_len < EXT64_MIN_LEN || frame_len[63]))
						fail_frame();
					else
						end_of_length();
				end
			end
			PH_KEY: begin
				mask_key = {mask_key[23:0], b};
				field_count = field_count + 4'd1;
				hdr_total = hdr_total + 4'd1;
				if (field_count == KEY_BYTES)
					close_header();
			end
			PH_PAYLOAD: begin
				kb = masked ? mask_key[8 * (3 - int'(key_idx)) +: 8] : 8'h00;
				key_idx = key_idx + 2'd1;
				if (remaining != '0)
					remaining = remaining - 63'd1;
				if (remaining == '0)
					phase = PH_BYTE1;
				emit(KIND_DATA, b ^ kb, remaining == '0);
			end
			default: begin
			end
			endcase
		endfunction

		task report(string what);
			if (errors < MAX_PRINTED)
				$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		endtask

		task check(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing expected, kind %0d", got.kind));
				return;
			end
			want = expected_q.pop_front();
			compare_field("kind", 64'(got.kind), 64'(want.kind));
			compare_field("fin_flag", 64'(got.fin_flag), 64'(want.fin_flag));
			compare_field("opcode", 64'(got.opcode), 64'(want.opcode));
			compare_field("masked_flag", 64'(got.masked_flag), 64'(want.masked_flag));
			compare_field("length", 64'(got.length), 64'(want.length));
			compare_field("header_bytes", 64'(got.header_bytes), 64'(want.header_bytes));
			compare_field("data_out", 64'(got.data_out), 64'(want.data_out));
			compare_field("last", 64'(got.last), 64'(want.last));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       byte_in = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       kind;
	logic             fin_flag;
	logic [3:0]       opcode;
	logic             masked_flag;
	logic [LEN_W-1:0] length;
	logic [3:0]       header_bytes;
	logic [7:0]       data_out;
	logic             last;

	frame_scoreboard sb = new();
	int unsigned bytes_sent = 0;
	int unsigned burst_left = 0;
	int unsigned sink_cycle = 0;
	sink_mode_t  sink_mode = SINK_FREE;

	websocket_frame_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.fin_flag(fin_flag),
		.opcode(opcode),
		.masked_flag(masked_flag),
		.length(length),
		.header_bytes(header_bytes),
		.data_out(data_out),
		.last(last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		sink_cycle <= sink_cycle + 1;
		if (sink_cycle % 256 == 0)
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
		case (sink_mode)
		SINK_FREE: out_ready <= 1'b1;
		SINK_HALF: out_ready <= sink_cycle[0];
		SINK_QUARTER: out_ready <= (sink_cycle % 4 == 0);
		default: out_ready <= ($urandom_range(0, 9) < 6);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check({kind, fin_flag, opcode, masked_flag, length, header_bytes, data_out, last});
	end

	// hold the word until accepted, then idle between bursts
	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		byte_in <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 1500) :
				$urandom_range(1, 24);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_header(input logic [7:0] first, input logic masked, input logic [6:0] ind,
		input logic [63:0] ext, input logic [31:0] mask_key);
		send_byte(first);
		send_byte({masked, ind});
		if (ind == IND_EXT16) begin
			for (int i = 1; i >= 0; i--)
				send_byte(ext[8 * i +: 8]);
		end else if (ind == IND_EXT64) begin
			for (int i = 7; i >= 0; i--)
				send_byte(ext[8 * i +: 8]);
		end
		if (masked) begin
			for (int i = 3; i >= 0; i--)
				send_byte(mask_key[8 * i +: 8]);
		end
	endtask

	task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
		input logic [63:0] len);
		logic [6:0]  ind;
		logic [31:0] mask_key;
		case ($urandom_range(0, 5))
		0: mask_key = '0;
		1: mask_key = '1;
		default: mask_key = $urandom;
		endcase
		if (len <= CTRL_MAX_LEN)
			ind = len[6:0];
		else if (len < EXT64_MIN_LEN)
			ind = IND_EXT16;
		else
			ind = IND_EXT64;
		send_header({fin, 3'b000, op}, masked, ind, len, mask_key);
		repeat (len)
			send_byte(8'($urandom));
	endtask

	task automatic random_frame();
		logic [3:0]  op;
		logic        fin;
		logic [63:0] len;
		int          sel;
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0) begin
			op = 4'($urandom_range(OP_CLOSE, OP_PONG));
			fin = 1'b1;
			len = (sel < 70) ? $urandom_range(0, 12) : $urandom_range(0, 125);
		end else begin
			op = 4'($urandom_range(OP_CONT, OP_BINARY));
			fin = 1'($urandom);
			if (sel < 60)
				len = $urandom_range(0, 12);
			else if (sel < 88)
				len = $urandom_range(13, 60);
			else
				len = $urandom_range(126, 220);
		end
		send_frame(fin, op, 1'($urandom), len);
	endtask

	// one broken frame ends the stream, since only reset revives the parser
	task automatic send_bad_frame();
		bad_frame_t  which;
		logic        masked;
		logic [31:0] mask_key;
		logic [3:0]  op;
		which = bad_frame_t'($urandom_range(BAD_SHORT16, BAD_CTRL_LONG));
		masked = 1'($urandom);
		mask_key = $urandom;
		case (which)
		BAD_SHORT16:
			send_header({1'b1, 3'b000, OP_BINARY}, masked, IND_EXT16,
				64'($urandom_range(0, 125)), mask_key);
		BAD_SHORT64:
			send_header({1'b1, 3'b000, OP_TEXT}, masked, IND_EXT64,
				64'($urandom_range(0, 65535)), mask_key);
		BAD_TOPBIT:
			send_header({1'b1, 3'b000, OP_BINARY}, masked, IND_EXT64,
				{1'b1, 31'($urandom), 32'($urandom)}, mask_key);
		BAD_RSV:
			send_header({1'($urandom), 3'($urandom_range(1, 7)), OP_TEXT}, masked,
				7'($urandom_range(0, 125)), '0, mask_key);
		BAD_OPCODE: begin
			op = $urandom_range(0, 1) ? 4'($urandom_range(OP_RSV_LO, OP_RSV_HI)) :
				4'($urandom_range(OP_RSV_CTRL, OP_RSV_TOP));
			send_header({1'b1, 3'b000, op}, masked, 7'($urandom_range(0, 125)), '0, mask_key);
		end
		BAD_CTRL_FRAG:
			send_header({1'b0, 3'b000, 4'($urandom_range(OP_CLOSE, OP_PONG))}, masked,
				7'($urandom_range(0, 125)), '0, mask_key);
		default:
			send_header({1'b1, 3'b000, 4'($urandom_range(OP_CLOSE, OP_PONG))}, masked,
				IND_EXT16, 64'($urandom_range(126, 65535)), mask_key);
		endcase
		repeat ($urandom_range(16, 48))
			send_byte(8'($urandom));
	endtask

	initial begin
		int unsigned start;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(1'b1, OP_TEXT, 1'b0, 0);
		send_frame(1'b1, OP_BINARY, 1'b1, 1);
		send_frame(1'b0, OP_CONT, 1'b0, 2);
		send_frame(1'b1, OP_CLOSE, 1'b1, 0);
		send_frame(1'b1, OP_PING, 1'b1, 5);
		send_frame(1'b1, OP_PONG, 1'b0, 1);
		wait_drained();

		send_frame(1'b1, OP_BINARY, 1'($urandom), 64'(MIN_EXT16));
		send_frame(1'($urandom), OP_TEXT, 1'($urandom), 64'd255);

		start = bytes_sent;
		while (bytes_sent - start < 950) begin
			random_frame();
			if ($urandom_range(0, 39) == 0)
				wait_drained();
		end

		send_bad_frame();
		wait_drained();
		repeat (8)
			@(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/wfp_pkg.sv
hw/rtl/wfp_core.sv
hw/rtl/wfp_out_reg.sv
hw/rtl/websocket_frame_parser_top.sv
tb/tb_websocket_frame_parser_top.sv
